### rtl/prc_pkg.sv
// Package: shared constants, types and codes for the retransmit cache.
`default_nettype none
package prc_pkg;
    localparam int RING_DEPTH = 32;
    localparam int CONN_COUNT = 4;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CONN_W     = 2;
    localparam int MEM_DEPTH  = CONN_COUNT * RING_DEPTH;
    localparam int MEM_W      = $clog2(MEM_DEPTH);
    localparam int STEP_W     = $clog2(RING_DEPTH + 1);
    localparam int CNT_W      = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_LOST  = 2'd1;
    localparam logic [1:0] MODE_RETX  = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    localparam logic [2:0] KIND_DONE  = 3'd0;
    localparam logic [2:0] KIND_ERROR = 3'd1;
    localparam logic [2:0] KIND_REL   = 3'd2;
    localparam logic [2:0] KIND_LOST  = 3'd3;
    localparam logic [2:0] KIND_RETX  = 3'd4;

    typedef enum logic [1:0] {
        OP_ERROR = 2'd0,
        OP_SLOT  = 2'd1,
        OP_SCAN  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_LOST = 3'b001,
        PH_REL  = 3'b010,
        PH_RETX = 3'b100
    } t_phase;

    typedef struct packed {
        t_op          op;
        logic [1:0]   mode;
        logic [CONN_W-1:0] conn;
        logic [31:0]  seq;
        logic [63:0]  handle;
        logic [5:0]   max_report;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [63:0] addr;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] released;
        logic        last;
    } t_res;
endpackage
`default_nettype wire

### rtl/psn_ring_retransmit_cache_core.sv
// Top level: sequence-number indexed retransmit cache.
// Items are classified and queued by the front end (two entries deep); the back
// end then runs one item at a time. Store and free items pass the read, slot and
// done states, error items the read and done states; lost and retransmit items
// pass a request and a check state per sequence number walked (at most RING_DEPTH
// per walk) for the slot memory's registered read. An output stall holds the back
// end. Slot occupancy lives in per-slot valid flags cleared at reset.
`default_nettype none
module psn_ring_retransmit_cache_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [1:0]   i_mode,
    input  wire logic [1:0]   i_conn_index,
    input  wire logic [31:0]  i_seq_num,
    input  wire logic [63:0]  i_buffer_handle,
    input  wire logic [13:0]  i_payload_len,
    input  wire logic [5:0]   i_max_report,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [2:0]        o_kind,
    output logic [31:0]       o_seq_out,
    output logic [63:0]       o_addr_out,
    output logic [10:0]       o_count_out,
    output logic [10:0]       o_released_count,
    output logic              o_last,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [13:0]  i_cfg_data
);
    logic [13:0] r_max_len;
    prc_pkg::t_cmd cmd;
    logic cmd_valid, cmd_take;
    prc_pkg::t_res res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_len <= 14'd5116;
        else if (i_cfg_valid) r_max_len <= i_cfg_data;
    end

    prc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_conn_index, .i_seq_num,
        .i_buffer_handle, .i_payload_len, .i_max_report,
        .i_max_len(r_max_len), .o_cmd(cmd), .o_cmd_valid(cmd_valid),
        .i_cmd_take(cmd_take)
    );

    prc_back u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .o_res(res), .o_res_valid(o_valid), .i_res_stall(i_stall)
    );

    assign o_kind = res.kind;
    assign o_seq_out = res.seq;
    assign o_addr_out = res.addr;
    assign o_count_out = res.count;
    assign o_released_count = res.released;
    assign o_last = res.last;
endmodule
`default_nettype wire

### rtl/prc_front.sv
// Front end: input beat acceptance, classification and command queue.
`default_nettype none
module prc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_mode,
    input  wire logic [1:0]    i_conn_index,
    input  wire logic [31:0]   i_seq_num,
    input  wire logic [63:0]   i_buffer_handle,
    input  wire logic [13:0]   i_payload_len,
    input  wire logic [5:0]    i_max_report,
    input  wire logic [13:0]   i_max_len,
    output prc_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_take
);
    prc_pkg::t_cmd r_q [prc_pkg::QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    prc_pkg::t_cmd n_cmd;
    logic bad;
    logic acc;

    always_comb begin
        bad = 1'b0;
        if ({30'd0, i_conn_index} >= prc_pkg::CONN_COUNT) bad = 1'b1;
        case (i_mode)
            prc_pkg::MODE_STORE: if (i_buffer_handle == 64'd0 || i_payload_len == 14'd0
                                     || i_payload_len > i_max_len) bad = 1'b1;
            prc_pkg::MODE_LOST:  if (i_max_report == 6'd0) bad = 1'b1;
            prc_pkg::MODE_RETX:  if (i_seq_num == 32'd0) bad = 1'b1;
            default: ;
        endcase
        n_cmd.mode = i_mode;
        n_cmd.conn = i_conn_index;
        n_cmd.seq = i_seq_num;
        n_cmd.handle = i_buffer_handle;
        n_cmd.max_report = i_max_report;
        if (bad) n_cmd.op = prc_pkg::OP_ERROR;
        else if (i_mode == prc_pkg::MODE_STORE || i_mode == prc_pkg::MODE_FREE)
            n_cmd.op = prc_pkg::OP_SLOT;
        else n_cmd.op = prc_pkg::OP_SCAN;
    end

    assign o_stall = (r_cnt == 2'd2);
    assign acc = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_cmd_take};
        end
    end
endmodule
`default_nettype wire

### rtl/prc_back.sv
// Back end: slot memory, range registers and the ring walks.
`default_nettype none
module prc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  prc_pkg::t_cmd      i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_take,
    output prc_pkg::t_res      o_res,
    output logic               o_res_valid,
    input  wire logic          i_res_stall
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_SLOT  = 7'b0000100,
        S_WREQ  = 7'b0001000,
        S_WCHK  = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

    t_state r_state;
    prc_pkg::t_cmd r_cmd;
    logic [63:0] r_mem [prc_pkg::MEM_DEPTH];
    logic [63:0] r_rd;
    logic [prc_pkg::RING_DEPTH-1:0] r_full [prc_pkg::CONN_COUNT];
    logic [31:0] r_low [prc_pkg::CONN_COUNT];
    logic [31:0] r_high [prc_pkg::CONN_COUNT];
    logic [32:0] r_p;
    logic [prc_pkg::STEP_W-1:0] r_steps;
    prc_pkg::t_phase r_phase;
    logic [prc_pkg::CNT_W-1:0] r_cnt, r_rel;
    logic [31:0] r_lo;
    logic [32:0] r_hi;

    prc_pkg::t_res r_out;
    logic r_out_v;
    logic out_free;
    logic out_load;
    logic [prc_pkg::MEM_W-1:0] cmd_addr, p_addr;
    logic walk_ok;
    logic cur_full;

    assign out_free = !r_out_v || !i_res_stall;
    assign o_res = r_out;
    assign o_res_valid = r_out_v;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign cmd_addr = {r_cmd.conn, r_cmd.seq[prc_pkg::SLOT_W-1:0]};
    assign p_addr = {r_cmd.conn, r_p[prc_pkg::SLOT_W-1:0]};
    assign cur_full = r_full[r_cmd.conn][r_p[prc_pkg::SLOT_W-1:0]];

    always_comb begin
        walk_ok = (r_p <= r_hi)
                  && (r_steps < (prc_pkg::STEP_W)'(prc_pkg::RING_DEPTH));
        case (r_phase)
            prc_pkg::PH_LOST: if (r_cnt >= {5'd0, r_cmd.max_report}) walk_ok = 1'b0;
            prc_pkg::PH_REL:  if (r_p >= {1'b0, r_cmd.seq}) walk_ok = 1'b0;
            default: ;
        endcase
    end

    always_comb begin
        out_load = 1'b0;
        if (out_free) begin
            case (r_state)
                S_SLOT: out_load = r_full[r_cmd.conn][r_cmd.seq[prc_pkg::SLOT_W-1:0]];
                S_WCHK: if (walk_ok) begin
                    out_load = (r_phase == prc_pkg::PH_LOST) ? !cur_full : cur_full;
                end
                S_DONE: out_load = 1'b1;
                default: ;
            endcase
        end
    end

    function automatic prc_pkg::t_res mk(logic [2:0] k, logic [31:0] s, logic [63:0] a,
                                         logic [prc_pkg::CNT_W-1:0] c,
                                         logic [prc_pkg::CNT_W-1:0] r, logic l);
        prc_pkg::t_res x;
        x.kind = k; x.seq = s; x.addr = a; x.count = c; x.released = r; x.last = l;
        return x;
    endfunction

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[p_addr];
        if (r_state == S_SLOT && out_free) begin
            if (r_cmd.mode == prc_pkg::MODE_STORE) r_mem[cmd_addr] <= r_cmd.handle;
        end
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out_v <= 1'b0;
            for (int i = 0; i < prc_pkg::CONN_COUNT; i++) begin
                r_full[i] <= '0;
                r_low[i] <= 32'd0;
                r_high[i] <= 32'd0;
            end
        end else begin
            r_out_v <= out_load || (r_out_v && !out_free);
            case (r_state)
                S_CLEAR: r_state <= S_IDLE;
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_p <= {1'b0, i_cmd.seq};
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_lo <= r_low[r_cmd.conn];
                    r_hi <= {1'b0, r_high[r_cmd.conn]};
                    r_cnt <= '0;
                    r_rel <= '0;
                    r_steps <= '0;
                    if (r_cmd.op == prc_pkg::OP_ERROR) begin
                        r_state <= S_DONE;
                    end else if (r_cmd.op == prc_pkg::OP_SLOT) begin
                        r_state <= S_SLOT;
                    end else if (r_low[r_cmd.conn] == 32'd0
                                 || r_low[r_cmd.conn] > r_high[r_cmd.conn]) begin
                        r_state <= S_DONE;
                    end else begin
                        r_p <= {1'b0, r_low[r_cmd.conn]};
                        r_phase <= (r_cmd.mode == prc_pkg::MODE_LOST) ? prc_pkg::PH_LOST
                                   : prc_pkg::PH_REL;
                        r_state <= S_WREQ;
                    end
                end
                S_SLOT: if (out_free) begin
                    if (r_full[r_cmd.conn][r_cmd.seq[prc_pkg::SLOT_W-1:0]]) begin
                        r_out <= mk(prc_pkg::KIND_REL, r_cmd.seq, r_rd, '0, '0, 1'b0);
                    end
                    r_full[r_cmd.conn][r_cmd.seq[prc_pkg::SLOT_W-1:0]]
                        <= (r_cmd.mode == prc_pkg::MODE_STORE);
                    if (r_cmd.mode == prc_pkg::MODE_STORE) begin
                        if (r_lo == 32'd0 || r_cmd.seq < r_lo)
                            r_low[r_cmd.conn] <= r_cmd.seq;
                        if (r_cmd.seq > r_hi[31:0]) r_high[r_cmd.conn] <= r_cmd.seq;
                    end
                    r_state <= S_DONE;
                end
                S_WREQ: r_state <= S_WCHK;
                S_WCHK: if (!walk_ok) begin
                    if (r_phase == prc_pkg::PH_REL) begin
                        r_phase <= prc_pkg::PH_RETX;
                        r_p <= {1'b0, r_cmd.seq};
                        r_steps <= '0;
                        r_state <= S_WREQ;
                    end else begin
                        if (r_phase == prc_pkg::PH_RETX) begin
                            if (r_cmd.seq > r_high[r_cmd.conn]) begin
                                r_low[r_cmd.conn] <= 32'd0;
                                r_high[r_cmd.conn] <= 32'd0;
                            end else begin
                                r_low[r_cmd.conn] <= r_cmd.seq;
                            end
                        end
                        r_state <= S_DONE;
                    end
                end else if (out_free) begin
                    case (r_phase)
                        prc_pkg::PH_LOST: if (!cur_full) begin
                            r_out <= mk(prc_pkg::KIND_LOST, r_p[31:0], 64'd0, '0, '0, 1'b0);
                            r_cnt <= r_cnt + 1'b1;
                        end
                        prc_pkg::PH_REL: if (cur_full) begin
                            r_out <= mk(prc_pkg::KIND_REL, r_p[31:0], r_rd, '0, '0, 1'b0);
                            r_rel <= r_rel + 1'b1;
                            r_full[r_cmd.conn][r_p[prc_pkg::SLOT_W-1:0]] <= 1'b0;
                        end
                        default: if (cur_full) begin
                            r_out <= mk(prc_pkg::KIND_RETX, r_p[31:0], r_rd, '0, '0, 1'b0);
                            r_cnt <= r_cnt + 1'b1;
                        end
                    endcase
                    r_p <= r_p + 33'd1;
                    r_steps <= r_steps + 1'b1;
                    r_state <= S_WREQ;
                end
                S_DONE: if (out_free) begin
                    r_out <= mk((r_cmd.op == prc_pkg::OP_ERROR) ? prc_pkg::KIND_ERROR
                                : prc_pkg::KIND_DONE, r_cmd.seq, 64'd0,
                                (r_cmd.op == prc_pkg::OP_SCAN) ? r_cnt : '0,
                                (r_cmd.op == prc_pkg::OP_SCAN) ? r_rel : '0, 1'b1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
